/* rtl/core/sidec_pkg.sv */
// Shared types and constants for the signed integer to decimal text block.
// No dependencies; used by the interfaces, the digit cells and the top level.
package sidec_pkg;

    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 31;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  ASCII_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'h2D;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_digit_row;

    // control handed from the sequencer to the row of digit cells
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctl;

endpackage

/* rtl/core/sidec_if.sv */
// Valid/ready channel interfaces for the integer word in and the character word out.
// Depends on sidec_pkg for field widths.
interface sidec_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sidec_pkg::VALUE_W-1:0]   value;
    logic        [sidec_pkg::COUNT_W-1:0]   count_before;

    modport source (output valid, value, count_before, input ready);
    modport sink   (input valid, value, count_before, output ready);
endinterface

interface sidec_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [sidec_pkg::CHAR_W-1:0]           char_code;
    logic [sidec_pkg::COUNT_W-1:0]          count_after;
    logic                                   last_char;

    modport source (output valid, char_code, count_after, last_char, input ready);
    modport sink   (input valid, char_code, count_after, last_char, output ready);
endinterface

/* rtl/core/sidec_digit_cell.sv */
// One BCD digit of the shift-and-add-3 converter row.
// Depends on sidec_pkg for the digit and control types.
module sidec_digit_cell (
    input  logic                  i_clk,
    input  sidec_pkg::t_cell_ctl  i_ctl,
    input  logic                  i_bit,
    output logic                  o_carry,
    output sidec_pkg::t_digit     o_digit
);

    sidec_pkg::t_digit r_digit;
    sidec_pkg::t_digit n_digit;
    sidec_pkg::t_digit w_adj;

    // correct before the shift so the digit never passes nine
    assign w_adj   = (r_digit >= sidec_pkg::t_digit'(5)) ?
                     r_digit + sidec_pkg::t_digit'(3) : r_digit;
    assign o_carry = w_adj[sidec_pkg::DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.shift) begin
            n_digit = {w_adj[sidec_pkg::DIGIT_W-2:0], i_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

/* rtl/core/sidec_bcd_chain.sv */
// Row of BCD digit cells; each shift moves one binary bit in at the least
// significant cell and passes carries upward. Depends on sidec_pkg, sidec_digit_cell.
module sidec_bcd_chain (
    input  logic                  i_clk,
    input  sidec_pkg::t_cell_ctl  i_ctl,
    input  logic                  i_bit,
    output sidec_pkg::t_digit_row o_digits
);

    logic [sidec_pkg::NUM_DIGITS:0] w_link;

    assign w_link[0] = i_bit;

    for (genvar g = 0; g < sidec_pkg::NUM_DIGITS; g++) begin : g_cell
        sidec_digit_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_bit   (w_link[g]),
            .o_carry (w_link[g+1]),
            .o_digit (o_digits[g])
        );
    end

    // the top carry is always zero for a 32-bit magnitude
    logic w_unused_carry;
    assign w_unused_carry = w_link[sidec_pkg::NUM_DIGITS];

endmodule

/* rtl/core/signed_int_to_decimal_ascii.sv */
// Signed 32-bit integer to decimal ASCII text, one character per output word.
// Channels: i_in carries value and count_before; o_out carries char_code,
// count_after and last_char. Both are valid/ready; a word moves when both are high.
// Each input word yields 1 to 11 output words, most significant digit first,
// with a leading '-' for negative values and no leading zeros.
// Sequence: the input word is taken, the magnitude then shifts through
// a row of ten BCD cells at one bit per cycle, a scan state finds the
// leading digit, then one character per cycle is loaded into the output register,
// as long as that register is empty or o_out is ready.
// The next input word is taken while the last character still waits in the
// output register. A stall on o_out holds the current character and pauses
// emission; nothing is dropped. Reset (i_rst_n low, synchronous) returns the
// sequencer to idle and empties the output register; no word is taken during reset.
// Depends on sidec_pkg, sidec_if, sidec_bcd_chain.
module signed_int_to_decimal_ascii (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sidec_in_if.sink       i_in,
    sidec_out_if.source    o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam int BIT_CNT_W = $clog2(sidec_pkg::VALUE_W);
    localparam int IDX_W     = $clog2(sidec_pkg::NUM_DIGITS);

    logic [1:0]                        r_state, n_state;
    logic [BIT_CNT_W-1:0]              r_bit_cnt, n_bit_cnt;
    logic [sidec_pkg::VALUE_W-1:0]     r_mag, n_mag;
    logic                              r_neg, n_neg;
    logic [sidec_pkg::COUNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]                  r_idx, n_idx;
    logic                              r_ovalid, n_ovalid;
    logic [sidec_pkg::CHAR_W-1:0]      r_char, n_char;
    logic [sidec_pkg::COUNT_W-1:0]     r_ocount, n_ocount;
    logic                              r_olast, n_olast;

    logic                              w_in_fire;
    logic                              w_out_load;
    logic [sidec_pkg::VALUE_W-1:0]     w_raw;
    logic [sidec_pkg::COUNT_W-1:0]     w_count_inc;
    logic [IDX_W-1:0]                  w_lead_idx;
    sidec_pkg::t_digit                 w_sel_digit;
    sidec_pkg::t_cell_ctl              w_ctl;
    sidec_pkg::t_digit_row             w_digits;

    sidec_bcd_chain u_chain (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_bit    (r_mag[sidec_pkg::VALUE_W-1]),
        .o_digits (w_digits)
    );

    assign i_in.ready      = (r_state == S_IDLE) && i_rst_n;
    assign w_in_fire       = i_in.valid && i_in.ready;
    assign w_out_load      = (r_state == S_EMIT) && (!r_ovalid || o_out.ready);
    assign w_raw           = i_in.value;
    assign w_count_inc     = (r_count == sidec_pkg::COUNT_MAX) ?
                             r_count : r_count + sidec_pkg::COUNT_W'(1);
    assign w_sel_digit     = w_digits[r_idx];

    assign w_ctl.clear     = w_in_fire;
    assign w_ctl.shift     = (r_state == S_CONV);

    assign o_out.valid       = r_ovalid;
    assign o_out.char_code   = r_char;
    assign o_out.count_after = r_ocount;
    assign o_out.last_char   = r_olast;

    // highest nonzero digit, zero when the whole value is zero
    always_comb begin
        w_lead_idx = '0;
        for (int i = 0; i < sidec_pkg::NUM_DIGITS; i++) begin
            if (w_digits[i] != '0) begin
                w_lead_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_count   = r_count;
        n_idx     = r_idx;
        n_ovalid  = r_ovalid;
        n_char    = r_char;
        n_ocount  = r_ocount;
        n_olast   = r_olast;

        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_neg     = w_raw[sidec_pkg::VALUE_W-1];
                    n_mag     = w_raw[sidec_pkg::VALUE_W-1] ?
                                (~w_raw + sidec_pkg::VALUE_W'(1)) : w_raw;
                    n_count   = i_in.count_before;
                    n_bit_cnt = '0;
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                n_mag     = {r_mag[sidec_pkg::VALUE_W-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt + BIT_CNT_W'(1);
                if (r_bit_cnt == BIT_CNT_W'(sidec_pkg::VALUE_W - 1)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_idx   = w_lead_idx;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_load) begin
                    n_ovalid = 1'b1;
                    n_count  = w_count_inc;
                    n_ocount = w_count_inc;
                    if (r_neg) begin
                        // sign goes out first, digits follow
                        n_char  = sidec_pkg::ASCII_MINUS;
                        n_olast = 1'b0;
                        n_neg   = 1'b0;
                    end else begin
                        n_char  = sidec_pkg::ASCII_ZERO +
                                  sidec_pkg::CHAR_W'(w_sel_digit);
                        n_olast = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx = r_idx - IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_bit_cnt <= n_bit_cnt;
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_count   <= n_count;
        r_idx     <= n_idx;
        r_char    <= n_char;
        r_ocount  <= n_ocount;
        r_olast   <= n_olast;
    end

    a_start_conv : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == S_CONV) && (r_bit_cnt == '0))
        else $error("conversion did not start after input word");

    a_char_legal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.char_code == sidec_pkg::ASCII_MINUS) ||
                        ((o_out.char_code >= sidec_pkg::ASCII_ZERO) &&
                         (o_out.char_code <= sidec_pkg::ASCII_NINE)))
        else $error("output character is not a sign or a digit");

    a_last_is_digit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_char) |-> (o_out.char_code != sidec_pkg::ASCII_MINUS))
        else $error("sign marked as final character");

    a_scan_digit_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (w_sel_digit <= sidec_pkg::t_digit'(9)))
        else $error("BCD digit out of range");

endmodule

/* sim/testbench.sv */
// Self-checking bench for signed_int_to_decimal_ascii: integer words in, ASCII words out.
// Depends on sidec_pkg and the sidec_in_if / sidec_out_if channel interfaces.
// Directed table first, then random words under bursty sending and a patterned sink.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [sidec_pkg::CHAR_W-1:0]  char_code;
        logic [sidec_pkg::COUNT_W-1:0] count_after;
        logic                          last_char;
    } t_char_word;

    typedef struct {
        logic signed [sidec_pkg::VALUE_W-1:0] value;
        logic [sidec_pkg::COUNT_W-1:0]        count_before;
        string                                text;
    } t_text_row;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_BURSTY
    } t_sink_mode;

    logic i_clk;
    logic i_rst_n;

    sidec_in_if  in_ch ();
    sidec_out_if out_ch ();

    signed_int_to_decimal_ascii dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_char_word pending_chars [$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         burst_left  = 0;

    t_sink_mode sink_mode = SINK_OPEN;
    int         mode_left = 0;
    int         run_left  = 0;
    logic       run_open  = 1'b1;

    // empty text: no typed expectation, the predictor supplies it
    t_text_row text_rows [20] = '{
        '{32'sd0,           31'd0,                          "0"},
        '{32'sd1,           31'd0,                          "1"},
        '{-32'sd1,          31'd0,                          "-1"},
        '{32'sd9,           31'd5,                          "9"},
        '{32'sd10,          31'd7,                          "10"},
        '{-32'sd10,         31'd0,                          "-10"},
        '{32'sd99,          31'd0,                          "99"},
        '{-32'sd100,        31'd3,                          "-100"},
        '{32'sh7FFF_FFFF,   31'd0,                          "2147483647"},
        '{32'sh8000_0000,   31'd0,                          "-2147483648"},
        '{32'sd1000000000,  31'd0,                          "1000000000"},
        '{32'sd999999999,   31'd12,                         "999999999"},
        '{-32'sd999999999,  31'd0,                          "-999999999"},
        '{32'sd5,           sidec_pkg::COUNT_MAX,           "5"},
        '{-32'sd7,          sidec_pkg::COUNT_MAX - 31'd1,   "-7"},
        '{32'sh8000_0000,   sidec_pkg::COUNT_MAX - 31'd5,   "-2147483648"},
        '{32'sh7FFF_FFFF,   sidec_pkg::COUNT_MAX - 31'd3,   "2147483647"},
        '{32'sd123456789,   31'h2AAA_AAAA,                  ""},
        '{-32'sd1515870810, 31'h5555_5555,                  ""},
        '{-32'sd2,          31'h7FFF_FF00,                  ""}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic logic [sidec_pkg::COUNT_W-1:0] bump_count(
        input logic [sidec_pkg::COUNT_W-1:0] count);
        return (count == sidec_pkg::COUNT_MAX) ? count : count + 1'b1;
    endfunction

    function automatic void predict_decimal_text(
        input logic signed [sidec_pkg::VALUE_W-1:0] value,
        input logic [sidec_pkg::COUNT_W-1:0]        count_before);
        logic [sidec_pkg::VALUE_W-1:0] mag;
        logic [sidec_pkg::DIGIT_W-1:0] digits [sidec_pkg::NUM_DIGITS];
        logic [sidec_pkg::COUNT_W-1:0] count;
        int                            ndig;
        count = count_before;
        // two's complement negate in unsigned terms covers the most negative value
        mag   = value[sidec_pkg::VALUE_W-1] ? (32'd0 - 32'(value)) : 32'(value);
        ndig  = 0;
        do begin
            digits[ndig] = sidec_pkg::DIGIT_W'(mag % 10);
            ndig++;
            mag = mag / 10;
        end while (mag != 0);
        if (value[sidec_pkg::VALUE_W-1]) begin
            count = bump_count(count);
            pending_chars.push_back('{sidec_pkg::ASCII_MINUS, count, 1'b0});
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            count = bump_count(count);
            pending_chars.push_back('{sidec_pkg::ASCII_ZERO + sidec_pkg::CHAR_W'(digits[i]),
                                      count, i == 0});
        end
    endfunction

    function automatic void expect_text(input string text,
                                        input logic [sidec_pkg::COUNT_W-1:0] count_before);
        logic [sidec_pkg::COUNT_W-1:0] count;
        count = count_before;
        for (int i = 0; i < text.len(); i++) begin
            count = bump_count(count);
            pending_chars.push_back('{sidec_pkg::CHAR_W'(text[i]), count,
                                      i == text.len() - 1});
        end
    endfunction

    function automatic logic signed [sidec_pkg::VALUE_W-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     ndig;
        logic   neg;
        int     pick;
        pick = $urandom_range(0, 9);
        neg  = 1'($urandom_range(0, 1));
        if (pick < 4) return $urandom();
        if (pick == 9) begin
            case ($urandom_range(0, 4))
                0: return 32'sd0;
                1: return 32'sh8000_0000;
                2: return 32'sh7FFF_FFFF;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        // pick a digit count first so every text length shows up often
        ndig = $urandom_range(1, 10);
        lo   = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi   = lo * 10 - 1;
        if (hi > 64'sd2147483647) hi = neg ? 64'sd2147483648 : 64'sd2147483647;
        mag  = lo + (longint'($urandom()) & 64'hFFFF_FFFF) % (hi - lo + 1);
        return neg ? sidec_pkg::VALUE_W'(-mag) : sidec_pkg::VALUE_W'(mag);
    endfunction

    function automatic logic [sidec_pkg::COUNT_W-1:0] random_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return sidec_pkg::COUNT_W'($urandom());
        if (pick < 9) return sidec_pkg::COUNT_W'($urandom_range(0, 40));
        return sidec_pkg::COUNT_MAX - sidec_pkg::COUNT_W'($urandom_range(0, 12));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic go_idle(input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // start a new burst after a random gap once the current one runs out
    task automatic pace_sender();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            go_idle($urandom_range(0, 20));
        end
        burst_left--;
    endtask

    task automatic send_word(input logic signed [sidec_pkg::VALUE_W-1:0] value,
                             input logic [sidec_pkg::COUNT_W-1:0] count_before,
                             input string text);
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.value        <= value;
        in_ch.count_before <= count_before;
        do @(posedge i_clk); while (!in_ch.ready);
        if (text.len() != 0) expect_text(text, count_before);
        else predict_decimal_text(value, count_before);
    endtask

    task automatic wait_for_drain();
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // sink: switch between stall patterns chosen at random
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(30, 200);
        end else begin
            mode_left--;
        end
        case (sink_mode)
            SINK_OPEN:   out_ch.ready <= 1'b1;
            SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (run_left == 0) begin
                    run_open = !run_open;
                    run_left = run_open ? $urandom_range(1, 12) : $urandom_range(1, 15);
                end else begin
                    run_left--;
                end
                out_ch.ready <= run_open;
            end
        endcase
    end

    always @(posedge i_clk) begin : watch_out
        t_char_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("word with nothing expected", 32'(out_ch.char_code), 32'd0);
            end else begin
                want = pending_chars.pop_front();
                if (out_ch.char_code !== want.char_code)
                    report_mismatch("char_code", 32'(out_ch.char_code), 32'(want.char_code));
                if (out_ch.count_after !== want.count_after)
                    report_mismatch("count_after", 32'(out_ch.count_after),
                                    32'(want.count_after));
                if (out_ch.last_char !== want.last_char)
                    report_mismatch("last_char", 32'(out_ch.last_char), 32'(want.last_char));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("testbench: errors");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.value        = '0;
        in_ch.count_before = '0;
        out_ch.ready       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (text_rows[r]) begin
            pace_sender();
            send_word(text_rows[r].value, text_rows[r].count_before, text_rows[r].text);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // hold off once until the block has emptied completely
            if (n == RANDOM_ITEMS / 2) begin
                go_idle(1);
                wait_for_drain();
            end
            pace_sender();
            send_word(random_value(), random_count(), "");
        end
        go_idle(1);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
